FILE: rtl/pwd_pkg.sv
package pwd_pkg;

  localparam int KIND_W = 3;
  localparam int QIDX_W = 4;
  localparam int TAG_W  = 32;
  localparam int WID_W  = 5;
  localparam int STAT_W = 2;
  localparam int OQ_W   = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_DATA_W = 6;

  localparam logic [KIND_W-1:0] KIND_ADD  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REQ  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DISP = 3'd2;
  localparam logic [KIND_W-1:0] KIND_IDLE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BUSY = 3'd4;

  localparam logic CFG_QUEUES  = 1'b0;
  localparam logic CFG_WORKERS = 1'b1;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_REQ,
    OP_DISP,
    OP_IDLE,
    OP_BUSY,
    OP_NOP
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_DENIED  = 2'd1,
    STAT_NONE    = 2'd2,
    STAT_DROPPED = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_FIN
  } state_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t               op;
    logic [QIDX_W-1:0] queue;
    logic [TAG_W-1:0]  tag;
    logic [WID_W-1:0]  wid;
    logic              wid_ok;
  } cmd_t;

  // configuration, already clamped to the legal range
  typedef struct packed {
    logic [4:0] nq;
    logic [6:0] nw;
  } cfg_t;

endpackage

FILE: rtl/priority_work_dispatcher.sv
// path: an accepted request is queued, then executed, then its result is loaded into the m_axis registers
// the back end takes no new command until the last one's result is loaded (execute, then result load)
// the execute cycle updates pointers and busy map and issues the single store access
// a two-entry command queue lets the front keep accepting while the output is stalled
// reset: synchronous, clears queues, busy map, handshakes; queues_in_use 1, workers_in_use 32
// no clearing pass: store entries are only read after being written
module priority_work_dispatcher #(
  parameter int QUEUES      = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int WORKERS     = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // queue_index[3:0], work_tag[35:4], worker_id[40:36], zero[47:41]
  input  logic [pwd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // kind[2:0]
  input  logic [pwd_pkg::KIND_W-1:0]      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_tag[31:0], out_worker[36:32], out_queue[38:37], can_assign[39],
  // work_done[40], zero[47:41]
  output logic [pwd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // status[1:0]
  output logic [pwd_pkg::STAT_W-1:0]      m_axis_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [pwd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import pwd_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  cfg_t cfg;

  pwd_front #(
    .QUEUES  (QUEUES),
    .WORKERS (WORKERS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .cfg           (cfg)
  );

  pwd_back #(
    .QUEUES      (QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .WORKERS     (WORKERS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .cfg           (cfg),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

FILE: rtl/pwd_ram.sv
module pwd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/pwd_front.sv
module pwd_front #(
  parameter int QUEUES  = 4,
  parameter int WORKERS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [pwd_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  input  logic [pwd_pkg::KIND_W-1:0]           s_axis_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [pwd_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                 cmd_valid,
  output pwd_pkg::cmd_t                        cmd,
  input  logic                                 cmd_pop,
  output pwd_pkg::cfg_t                        cfg
);

  import pwd_pkg::*;

  localparam logic [4:0] NQ_MAX = 5'(QUEUES);
  localparam logic [6:0] NW_MAX = 7'(WORKERS);
  localparam logic [6:0] NW_RST = 7'((WORKERS < 32) ? WORKERS : 32);

  cmd_t       fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  cmd_t       cls;

  logic [QIDX_W-1:0] qreq;
  logic [4:0]        nq_wr;
  logic [6:0]        nw_wr;

  assign cfg_ready = 1'b1;

  // clamp configuration on write
  always_comb begin
    nq_wr = {2'b00, cfg_data[2:0]};
    if (nq_wr == 5'd0) nq_wr = 5'd1;
    if (nq_wr > NQ_MAX) nq_wr = NQ_MAX;
    nw_wr = {1'b0, cfg_data};
    if (nw_wr > NW_MAX) nw_wr = NW_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nq <= 5'd1;
      cfg.nw <= NW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_QUEUES:  cfg.nq <= nq_wr;
        CFG_WORKERS: cfg.nw <= nw_wr;
        default: ;
      endcase
    end
  end

  // classify the incoming request
  always_comb begin
    qreq = s_axis_tdata[QIDX_W-1:0];
    if ({1'b0, qreq} >= cfg.nq) qreq = QIDX_W'(cfg.nq - 5'd1);
    cls.queue  = qreq;
    cls.tag    = s_axis_tdata[QIDX_W +: TAG_W];
    cls.wid    = s_axis_tdata[QIDX_W+TAG_W +: WID_W];
    cls.wid_ok = ({2'b00, cls.wid} < NW_MAX);
    unique case (s_axis_tuser)
      KIND_ADD:  cls.op = OP_ADD;
      KIND_REQ:  cls.op = OP_REQ;
      KIND_DISP: cls.op = OP_DISP;
      KIND_IDLE: cls.op = OP_IDLE;
      KIND_BUSY: cls.op = OP_BUSY;
      default:   cls.op = OP_NOP;
    endcase
  end

  assign s_axis_tready = (fill != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid     = (fill != 2'd0);
  assign cmd           = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

FILE: rtl/pwd_back.sv
module pwd_back #(
  parameter int QUEUES      = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int WORKERS     = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  pwd_pkg::cmd_t                   cmd,
  output logic                            cmd_pop,
  input  pwd_pkg::cfg_t                   cfg,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [pwd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic [pwd_pkg::STAT_W-1:0]      m_axis_tuser
);

  import pwd_pkg::*;

  localparam int QI_W  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int WI_W  = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int MEM_D = QUEUES * QUEUE_DEPTH;
  localparam int AW    = (MEM_D > 1) ? $clog2(MEM_D) : 1;
  localparam logic [CNT_W-1:0] FULL    = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(QUEUE_DEPTH - 1);

  state_t state;
  state_t state_next;

  logic [PTR_W-1:0]   heads  [QUEUES];
  logic [PTR_W-1:0]   tails  [QUEUES];
  logic [CNT_W-1:0]   counts [QUEUES];
  logic [WORKERS-1:0] busy;

  logic [QI_W-1:0]    q;
  logic               full;
  logic [WORKERS-1:0] amask;
  logic [WORKERS-1:0] idle_vec;
  logic [WORKERS-1:0] pick;
  logic [WORKERS-1:0] busy_act;
  logic               w_any;
  logic [WI_W-1:0]    w_idx;
  logic               q_any;
  logic [QI_W-1:0]    q_hi;
  logic               disp_ok;
  logic               push_ok;
  logic [WI_W-1:0]    wid;
  logic               out_load;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [TAG_W-1:0]  ram_rdata;

  status_t           p_status;
  logic [WID_W-1:0]  p_worker;
  logic [OQ_W-1:0]   p_queue;
  logic              p_take_tag;

  logic              can_assign;
  logic              work_done;
  logic [TAG_W-1:0]  res_tag;

  pwd_ram #(
    .WIDTH (TAG_W),
    .DEPTH (MEM_D)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.tag),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // worker search and queue selection
  always_comb begin
    for (int i = 0; i < WORKERS; i++) begin
      amask[i] = (7'(i) < cfg.nw);
    end
    idle_vec = ~busy & amask;
    pick     = idle_vec & (~idle_vec + 1'b1);
    w_any    = |idle_vec;
    w_idx    = '0;
    for (int i = 0; i < WORKERS; i++) begin
      if (pick[i]) w_idx = w_idx | WI_W'(i);
    end
    busy_act = busy & amask;
    q_any = 1'b0;
    q_hi  = '0;
    for (int i = 0; i < QUEUES; i++) begin
      if ((5'(i) < cfg.nq) && (counts[i] != '0)) begin
        q_any = 1'b1;
        q_hi  = QI_W'(i);
      end
    end
  end

  assign q       = cmd.queue[QI_W-1:0];
  assign full    = (counts[q] == FULL);
  assign wid     = WI_W'(cmd.wid);
  assign cmd_pop = (state == ST_IDLE) && cmd_valid;
  assign push_ok = cmd_pop && (cmd.op == OP_ADD || cmd.op == OP_REQ) && !full;
  assign disp_ok = cmd_pop && (cmd.op == OP_DISP) && w_any && q_any;
  assign out_load = (state == ST_FIN) && (!m_axis_tvalid || m_axis_tready);

  assign ram_we    = push_ok;
  assign ram_waddr = AW'(q) * AW'(QUEUE_DEPTH) + AW'(tails[q]);
  assign ram_re    = disp_ok;
  assign ram_raddr = AW'(q_hi) * AW'(QUEUE_DEPTH) + AW'(heads[q_hi]);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd_valid) state_next = ST_FIN;
      ST_FIN:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // queue pointers and busy map
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUES; i++) begin
        heads[i]  <= '0;
        tails[i]  <= '0;
        counts[i] <= '0;
      end
      busy <= '0;
    end else begin
      if (push_ok) begin
        tails[q]  <= (tails[q] == PTR_TOP) ? '0 : tails[q] + 1'b1;
        counts[q] <= counts[q] + 1'b1;
      end
      if (disp_ok) begin
        heads[q_hi]  <= (heads[q_hi] == PTR_TOP) ? '0 : heads[q_hi] + 1'b1;
        counts[q_hi] <= counts[q_hi] - 1'b1;
        busy         <= busy | pick;
      end
      if (cmd_pop && cmd.wid_ok && cmd.op == OP_IDLE) busy[wid] <= 1'b0;
      if (cmd_pop && cmd.wid_ok && cmd.op == OP_BUSY) busy[wid] <= 1'b1;
    end
  end

  // result fields held until the output stage is free
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      p_status   <= STAT_OK;
      p_worker   <= '0;
      p_queue    <= '0;
      p_take_tag <= 1'b0;
      case (cmd.op) inside
        OP_ADD, OP_REQ: begin
          p_queue <= OQ_W'(q);
          if (full) p_status <= (cmd.op == OP_ADD) ? STAT_DROPPED : STAT_DENIED;
        end
        OP_DISP: begin
          if (w_any && q_any) begin
            p_worker   <= WID_W'(w_idx);
            p_queue    <= OQ_W'(q_hi);
            p_take_tag <= 1'b1;
          end else begin
            p_status <= STAT_NONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    can_assign = q_any && w_any;
    work_done  = !q_any && ((busy_act & (busy_act - 1'b1)) == '0);
    res_tag    = p_take_tag ? ram_rdata : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {7'b0, work_done, can_assign, p_queue, p_worker, res_tag};
      m_axis_tuser <= p_status;
    end
  end

  a_exec_then_fin: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (state == ST_FIN))
    else $error("command taken without moving to result stage");

  a_ram_one_port: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("store written and read in one cycle");

  a_dispatch_busy: assert property (@(posedge clk) disable iff (rst)
    disp_ok |=> ((busy & $past(pick)) != '0))
    else $error("dispatched worker not marked busy");

  a_no_pop_in_fin: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> !cmd_pop && !ram_we && !ram_re)
    else $error("state touched while a result is pending");

endmodule

FILE: dv/priority_work_dispatcher_checker.sv
`timescale 1ns / 100ps

module priority_work_dispatcher_checker #(
  parameter int QUEUES      = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int WORKERS     = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [pwd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [pwd_pkg::KIND_W-1:0]     s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [pwd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [pwd_pkg::STAT_W-1:0]     m_axis_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [pwd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending
);

  import pwd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    status_t          status;
    logic [TAG_W-1:0] tag;
    logic [WID_W-1:0] worker;
    logic [OQ_W-1:0]  queue;
    logic             can_assign;
    logic             work_done;
  } dispatch_reply_t;

  logic [TAG_W-1:0] tag_store [QUEUES][QUEUE_DEPTH];
  logic [PTR_W-1:0] head_ptr [QUEUES];
  logic [PTR_W-1:0] tail_ptr [QUEUES];
  int               fill [QUEUES];
  logic [WORKERS-1:0] busy_map;
  logic [2:0]       queues_reg;
  logic [5:0]       workers_reg;

  dispatch_reply_t  replies_owed [$];
  int               mismatches = 0;

  function automatic int live_queues();
    if (queues_reg == 0) return 1;
    if (queues_reg > QUEUES) return QUEUES;
    return int'(queues_reg);
  endfunction

  function automatic int live_workers();
    return (workers_reg > WORKERS) ? WORKERS : int'(workers_reg);
  endfunction

  function automatic int lowest_idle();
    int found;
    found = -1;
    for (int i = live_workers() - 1; i >= 0; i--)
      if (!busy_map[i]) found = i;
    return found;
  endfunction

  function automatic int busy_total();
    int n;
    n = 0;
    for (int i = 0; i < live_workers(); i++)
      n += int'(busy_map[i]);
    return n;
  endfunction

  function automatic bit work_waiting();
    bit any;
    any = 1'b0;
    for (int i = 0; i < live_queues(); i++)
      if (fill[i] != 0) any = 1'b1;
    return any;
  endfunction

  // one request against the dispatcher state, returning the reply it earns
  task automatic apply_command(input logic [KIND_W-1:0] kind, input logic [QIDX_W-1:0] qreq,
                               input logic [TAG_W-1:0] tag, input logic [WID_W-1:0] wid,
                               output dispatch_reply_t r);
    int nq;
    int qi;
    int w;
    int q;
    r = '0;
    r.status = STAT_OK;
    nq = live_queues();
    qi = (qreq >= nq) ? nq - 1 : int'(qreq);
    case (kind) inside
      KIND_ADD, KIND_REQ: begin
        r.queue = OQ_W'(qi);
        if (fill[qi] >= QUEUE_DEPTH) begin
          r.status = (kind == KIND_ADD) ? STAT_DROPPED : STAT_DENIED;
        end else begin
          tag_store[qi][tail_ptr[qi]] = tag;
          tail_ptr[qi] = tail_ptr[qi] + 1'b1;
          fill[qi]++;
        end
      end
      KIND_DISP: begin
        w = lowest_idle();
        q = -1;
        if (w >= 0)
          for (int i = nq - 1; i >= 0; i--)
            if (q < 0 && fill[i] != 0) q = i;
        if (w >= 0 && q >= 0) begin
          r.tag = tag_store[q][head_ptr[q]];
          head_ptr[q] = head_ptr[q] + 1'b1;
          fill[q]--;
          busy_map[w] = 1'b1;
          r.worker = WID_W'(w);
          r.queue = OQ_W'(q);
        end else begin
          r.status = STAT_NONE;
        end
      end
      KIND_IDLE: if (wid < WORKERS) busy_map[wid] = 1'b0;
      KIND_BUSY: if (wid < WORKERS) busy_map[wid] = 1'b1;
      default: ;
    endcase
    r.can_assign = work_waiting() && lowest_idle() >= 0;
    r.work_done = !work_waiting() && busy_total() <= 1;
  endtask

  task automatic check_field(input string name, input logic [TAG_W-1:0] want,
                             input logic [TAG_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    dispatch_reply_t want;
    dispatch_reply_t fresh;
    if (rst) begin
      for (int i = 0; i < QUEUES; i++) begin
        head_ptr[i] = '0;
        tail_ptr[i] = '0;
        fill[i] = 0;
      end
      busy_map = '0;
      queues_reg = 3'd1;
      workers_reg = 6'd32;
      replies_owed.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_QUEUES) queues_reg = cfg_data[2:0];
        else workers_reg = cfg_data[5:0];
      end
      // replies leave before the request of this edge can have one
      if (m_axis_tvalid && m_axis_tready) begin
        if (replies_owed.size() == 0) begin
          mismatches++;
          $error("reply with no request outstanding: tdata %0h, tuser %0h",
                 m_axis_tdata, m_axis_tuser);
        end else begin
          want = replies_owed.pop_front();
          check_field("status", TAG_W'(want.status), TAG_W'(m_axis_tuser));
          check_field("out_tag", want.tag, m_axis_tdata[31:0]);
          check_field("out_worker", TAG_W'(want.worker), TAG_W'(m_axis_tdata[36:32]));
          check_field("out_queue", TAG_W'(want.queue), TAG_W'(m_axis_tdata[38:37]));
          check_field("can_assign", TAG_W'(want.can_assign), TAG_W'(m_axis_tdata[39]));
          check_field("work_done", TAG_W'(want.work_done), TAG_W'(m_axis_tdata[40]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_command(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[35:4],
                      s_axis_tdata[40:36], fresh);
        replies_owed.push_back(fresh);
      end
    end
    pending <= replies_owed.size();
    errors <= mismatches;
  end

endmodule

FILE: dv/priority_work_dispatcher_tb.sv
`timescale 1ns / 100ps

module priority_work_dispatcher_tb;
  import pwd_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [KIND_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]     m_axis_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;

  int sender_gap_pct = 30;
  bit hold_output_due = 1'b0;

  priority_work_dispatcher dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  priority_work_dispatcher_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random ready pattern, plus one long hold-off on demand
  initial begin
    int run;
    int gap;
    m_axis_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 16);
      repeat (run) @(posedge clk);
      if (hold_output_due) begin
        hold_output_due = 1'b0;
        gap = 300;
      end else if ($urandom_range(0, 14) == 0) begin
        gap = $urandom_range(15, 50);
      end else if ($urandom_range(0, 2) == 0) begin
        gap = 0;
      end else begin
        gap = $urandom_range(1, 3);
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  task automatic offer(input logic [KIND_W-1:0] kind, input logic [QIDX_W-1:0] qidx,
                       input logic [TAG_W-1:0] tag, input logic [WID_W-1:0] wid);
    int gap;
    gap = 0;
    if ($urandom_range(1, 100) <= sender_gap_pct)
      gap = ($urandom_range(0, 14) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= IN_DATA_W'({wid, tag, qidx});
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic offer_random(input bit fill_heavy);
    int pick;
    logic [KIND_W-1:0] kind;
    logic [QIDX_W-1:0] qidx;
    logic [WID_W-1:0]  wid;
    pick = $urandom_range(0, 99);
    if (pick < (fill_heavy ? 40 : 15)) kind = KIND_ADD;
    else if (pick < (fill_heavy ? 55 : 25)) kind = KIND_REQ;
    else if (pick < (fill_heavy ? 75 : 60)) kind = KIND_DISP;
    else if (pick < (fill_heavy ? 90 : 88)) kind = KIND_IDLE;
    else if (pick < (fill_heavy ? 95 : 94)) kind = KIND_BUSY;
    else kind = KIND_W'(KIND_BUSY + $urandom_range(1, 3));
    qidx = ($urandom_range(0, 1) == 0) ? QIDX_W'($urandom_range(0, 3))
                                       : QIDX_W'($urandom_range(0, 15));
    wid = ($urandom_range(0, 2) == 0) ? WID_W'($urandom_range(0, 31))
                                      : WID_W'($urandom_range(0, 7));
    offer(kind, qidx, TAG_W'($urandom), wid);
  endtask

  // every reply in, then a margin for the pipeline before touching registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] queues_word,
                            input logic [CFG_DATA_W-1:0] workers_word);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_QUEUES;
    cfg_data <= queues_word;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_WORKERS;
    cfg_data <= workers_word;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    bit         fill_heavy;
    logic [2:0] qsel;
    logic [CFG_DATA_W-1:0] qword;
    logic [CFG_DATA_W-1:0] wword;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_QUEUES;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one queue, all workers
    offer(KIND_DISP, '0, '0, '0);
    offer(KIND_ADD, '1, '1, '0);
    offer(KIND_REQ, '0, '0, '0);
    offer(KIND_DISP, '0, '0, '0);
    offer(KIND_BUSY, '0, '0, '1);
    offer(KIND_IDLE, '0, '0, '0);
    offer(KIND_W'(KIND_BUSY + 1), '1, '1, '1);
    offer(KIND_W'(KIND_BUSY + 3), '0, '0, '0);
    // fill the single queue, then one add dropped and one request denied
    repeat (15) offer(KIND_ADD, QIDX_W'($urandom), TAG_W'($urandom), WID_W'($urandom));
    offer(KIND_ADD, '1, TAG_W'($urandom), '0);
    offer(KIND_REQ, '0, TAG_W'($urandom), '0);

    for (int phase = 0; phase < 12; phase++) begin
      settle();
      case (phase)
        0: begin qword = '1; wword = '1; end
        1: begin qword = '0; wword = '0; end
        2: begin qword = 6'd4; wword = 6'd1; end
        3: begin qword = 6'd2; wword = 6'd32; end
        4: begin qword = 6'd3; wword = 6'd2; end
        default: begin
          qsel = 3'($urandom_range(0, 7));
          qword = {3'($urandom), qsel};
          wword = ($urandom_range(0, 1) == 0) ? CFG_DATA_W'($urandom_range(0, 6))
                                              : CFG_DATA_W'($urandom_range(0, 63));
        end
      endcase
      set_config(qword, wword);
      fill_heavy = (phase % 3) != 1;
      sender_gap_pct = (phase % 4 == 3) ? 0 : 35;
      if (phase == 2) hold_output_due = 1'b1;
      repeat (156) offer_random(fill_heavy);
    end

    settle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/pwd_pkg.sv
rtl/pwd_ram.sv
rtl/pwd_front.sv
rtl/pwd_back.sv
rtl/priority_work_dispatcher.sv
dv/priority_work_dispatcher_checker.sv
dv/priority_work_dispatcher_tb.sv
